>>> src/klt_pkg.sv
// ----------------------------------------------------------------------------
// klt_pkg: shared definitions for the keyed list table
// Opcodes, status codes, field widths, select defaults and the compare
// result that the shared compare unit hands to the sequencer.
// ----------------------------------------------------------------------------
package klt_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int OP_W   = 4;
  localparam int KEY_W  = 16;
  localparam int CLS_W  = 8;
  localparam int RANK_W = 8;
  localparam int CNT_W  = 8;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 4'd1;
  localparam logic [OP_W-1:0] OP_COUNT2 = 4'd2;
  localparam logic [OP_W-1:0] OP_SEL2   = 4'd3;
  localparam logic [OP_W-1:0] OP_SELNZ  = 4'd4;
  localparam logic [OP_W-1:0] OP_SELN1  = 4'd5;
  localparam logic [OP_W-1:0] OP_SORT   = 4'd6;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd7;
  localparam logic [OP_W-1:0] OP_READ   = 4'd8;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  localparam logic [CLS_W-1:0] CLS_TWO  = 8'd2;
  localparam logic [CLS_W-1:0] CLS_ZERO = 8'd0;
  localparam logic [CLS_W-1:0] CLS_ONE  = 8'd1;

  localparam logic signed [KEY_W-1:0] DEFAULT_SEL2  = 16'sd3724;
  localparam logic signed [KEY_W-1:0] DEFAULT_OTHER = -16'sd1;

  typedef struct packed {
    logic key_eq;    // stored key equals the reference key
    logic key_gt;    // stored key is greater (signed) than the reference key
    logic cls_pass;  // stored class passes the filter of the current opcode
  } cmp_t;

endpackage

>>> src/klt_mem.sv
// ----------------------------------------------------------------------------
// klt_mem: entry storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module klt_mem #(
  parameter int DEPTH = klt_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(klt_pkg::MAX_ENTRIES_DEF)
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [klt_pkg::KEY_W-1:0]    wkey,
  input  logic [klt_pkg::CLS_W-1:0]           wcls,
  input  logic [AW-1:0]                       raddr,
  output logic signed [klt_pkg::KEY_W-1:0]    rkey,
  output logic [klt_pkg::CLS_W-1:0]           rcls
);

  logic [klt_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [klt_pkg::CLS_W-1:0] cls_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      cls_mem[waddr] <= wcls;
    end
  end

  always_ff @(posedge clk) begin
    rkey <= key_mem[raddr];
    rcls <= cls_mem[raddr];
  end

endmodule

>>> src/klt_cmp.sv
// ----------------------------------------------------------------------------
// klt_cmp: shared compare unit
// Compares one stored entry against the reference key and the class filter
// of the current opcode; used by remove, count, select and sort.
// ----------------------------------------------------------------------------
module klt_cmp (
  input  logic [klt_pkg::OP_W-1:0]         op,
  input  logic signed [klt_pkg::KEY_W-1:0] ent_key,
  input  logic [klt_pkg::CLS_W-1:0]        ent_cls,
  input  logic signed [klt_pkg::KEY_W-1:0] ref_key,
  output klt_pkg::cmp_t                    res
);

  always_comb begin
    res.key_eq = (ent_key == ref_key);
    res.key_gt = (ent_key > ref_key);
    if (op inside {klt_pkg::OP_SEL2, klt_pkg::OP_COUNT2}) begin
      res.cls_pass = (ent_cls == klt_pkg::CLS_TWO);
    end else if (op == klt_pkg::OP_SELNZ) begin
      res.cls_pass = (ent_cls != klt_pkg::CLS_ZERO);
    end else begin
      res.cls_pass = (ent_cls != klt_pkg::CLS_ONE);
    end
  end

endmodule

>>> src/keyed_list_table_with_filtered_select.sv
// One transaction at a time: the sequencer issues one memory read and one
//   compare per step, and the data of each read is registered before it is compared.
// Reset clears the entry count, the sequencer and the output valid; entry
//   storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// keyed_list_table_with_filtered_select: ordered key/class table
// A small sequencer walks the entry memory through one shared compare unit
// to insert, remove, count, select by filtered rank, sort, clear and read.
// ----------------------------------------------------------------------------
module keyed_list_table_with_filtered_select #(
  parameter int MAX_ENTRIES = klt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [klt_pkg::OP_W-1:0]            opcode,
  input  logic signed [klt_pkg::KEY_W-1:0]    key,
  input  logic [klt_pkg::CLS_W-1:0]           entry_class,
  input  logic [klt_pkg::RANK_W-1:0]          rank,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [klt_pkg::KEY_W-1:0]    key_out,
  output logic [klt_pkg::CLS_W-1:0]           class_out,
  output logic [klt_pkg::CNT_W-1:0]           count_out,
  output logic [klt_pkg::ST_W-1:0]            status
);

  localparam int AW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_RD    = 4'd1;
  localparam logic [3:0] S_INS_WR    = 4'd2;
  localparam logic [3:0] S_INS_HEAD  = 4'd3;
  localparam logic [3:0] S_SCAN_RD   = 4'd4;
  localparam logic [3:0] S_SCAN_EV   = 4'd5;
  localparam logic [3:0] S_SHIFT_RD  = 4'd6;
  localparam logic [3:0] S_SHIFT_WR  = 4'd7;
  localparam logic [3:0] S_SORT_RDI  = 4'd8;
  localparam logic [3:0] S_SORT_HOLD = 4'd9;
  localparam logic [3:0] S_SORT_RDJ  = 4'd10;
  localparam logic [3:0] S_SORT_EV   = 4'd11;
  localparam logic [3:0] S_SORT_PUT  = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0] state;
  logic [CW-1:0] count;      // entries held
  logic [CW-1:0] idx;        // walk position
  logic [CW-1:0] jdx;        // sort insertion position
  logic [CW-1:0] fcnt;       // filtered entries seen so far
  logic [klt_pkg::OP_W-1:0] op_r;
  logic signed [klt_pkg::KEY_W-1:0] key_r;
  logic [klt_pkg::CLS_W-1:0] cls_r;
  logic [klt_pkg::RANK_W-1:0] rank_r;
  logic signed [klt_pkg::KEY_W-1:0] hold_key;
  logic [klt_pkg::CLS_W-1:0] hold_cls;
  logic signed [klt_pkg::KEY_W-1:0] res_key;
  logic [klt_pkg::CLS_W-1:0] res_cls;
  logic [klt_pkg::ST_W-1:0] res_status;

  // Index arithmetic, one bit wider where a sum can reach past the depth
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] jdx_dec;
  logic [CW:0]   idx_inc;
  logic [CW:0]   idx_inc2;
  logic [CW:0]   count_ext;
  logic          out_free;

  assign idx_dec   = idx - 1'b1;
  assign jdx_dec   = jdx - 1'b1;
  assign idx_inc   = {1'b0, idx} + 1'b1;
  assign idx_inc2  = {1'b0, idx} + 2'd2;
  assign count_ext = {1'b0, count};
  assign out_free  = !out_valid || !out_stall;

  // Accept only from idle; the sequencer owns the table until the result
  // has been handed to the output register.
  assign in_stall = (state != S_IDLE);

  // Memory ports
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [klt_pkg::KEY_W-1:0]  mem_wkey;
  logic [klt_pkg::CLS_W-1:0]         mem_wcls;
  logic [AW-1:0]                     mem_raddr;
  logic signed [klt_pkg::KEY_W-1:0]  rkey;
  logic [klt_pkg::CLS_W-1:0]         rcls;

  klt_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (mem_wkey),
    .wcls  (mem_wcls),
    .raddr (mem_raddr),
    .rkey  (rkey),
    .rcls  (rcls)
  );

  // Shared compare unit: the reference key is the held sort key during a
  // sort and the transaction's key otherwise.
  klt_pkg::cmp_t cmp;
  logic signed [klt_pkg::KEY_W-1:0] cmp_ref;

  assign cmp_ref = (op_r == klt_pkg::OP_SORT) ? hold_key : key_r;

  klt_cmp u_cmp (
    .op      (op_r),
    .ent_key (rkey),
    .ent_cls (rcls),
    .ref_key (cmp_ref),
    .res     (cmp)
  );

  // Read address per state
  always_comb begin
    case (state)
      S_INS_RD:   mem_raddr = idx_dec[AW-1:0];
      S_SHIFT_RD: mem_raddr = idx_inc[AW-1:0];
      S_SORT_RDJ: mem_raddr = jdx_dec[AW-1:0];
      default:    mem_raddr = idx[AW-1:0];
    endcase
  end

  // Write port per state: shifts move the last read entry, head and sort
  // placement write the held entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wkey  = rkey;
    mem_wcls  = rcls;
    case (state)
      S_INS_WR: begin
        mem_we = 1'b1;
      end
      S_INS_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wkey  = key_r;
        mem_wcls  = cls_r;
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      S_SORT_EV: begin
        mem_we    = 1'b1;
        mem_waddr = jdx[AW-1:0];
        if (!cmp.key_gt) begin
          mem_wkey = hold_key;
          mem_wcls = hold_cls;
        end
      end
      S_SORT_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = jdx[AW-1:0];
        mem_wkey  = hold_key;
        mem_wcls  = hold_cls;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the output once the consumer takes it, unless a new result
      // loads in the same cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= opcode;
            key_r      <= key;
            cls_r      <= entry_class;
            rank_r     <= rank;
            res_key    <= '0;
            res_cls    <= '0;
            res_status <= klt_pkg::ST_OK;
            fcnt       <= '0;
            idx        <= '0;
            state      <= S_DONE;
            case (opcode)
              klt_pkg::OP_INSERT: begin
                if (count == CW'(MAX_ENTRIES)) begin
                  res_status <= klt_pkg::ST_FULL;
                end else begin
                  // Shift from the back toward the front, then write the head
                  idx   <= count;
                  state <= (count == '0) ? S_INS_HEAD : S_INS_RD;
                end
              end
              klt_pkg::OP_REMOVE, klt_pkg::OP_COUNT2, klt_pkg::OP_SEL2,
              klt_pkg::OP_SELNZ, klt_pkg::OP_SELN1: begin
                if (opcode != klt_pkg::OP_COUNT2) begin
                  res_status <= klt_pkg::ST_MISS;
                end
                if (opcode == klt_pkg::OP_SEL2) begin
                  res_key <= klt_pkg::DEFAULT_SEL2;
                end else if (opcode inside {klt_pkg::OP_SELNZ, klt_pkg::OP_SELN1}) begin
                  res_key <= klt_pkg::DEFAULT_OTHER;
                end
                if (count != '0) begin
                  state <= S_SCAN_RD;
                end
              end
              klt_pkg::OP_SORT: begin
                // Insertion sort: take entry idx, sink it past larger keys
                idx <= CW'(1);
                if (count_ext >= (CW+1)'(2)) begin
                  state <= S_SORT_RDI;
                end
              end
              klt_pkg::OP_CLEAR: begin
                count <= '0;
              end
              klt_pkg::OP_READ: begin
                if (rank < 8'(count)) begin
                  idx   <= CW'(rank);
                  state <= S_SCAN_RD;
                end else begin
                  res_status <= klt_pkg::ST_MISS;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_INS_RD: begin
          state <= S_INS_WR;
        end

        S_INS_WR: begin
          idx   <= idx_dec;
          state <= (idx_dec == '0) ? S_INS_HEAD : S_INS_RD;
        end

        S_INS_HEAD: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end

        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end

        S_SCAN_EV: begin
          // Advance by default; the cases below override on a hit
          if (idx_inc < count_ext) begin
            idx   <= idx_inc[CW-1:0];
            state <= S_SCAN_RD;
          end else begin
            state <= S_DONE;
          end
          case (op_r)
            klt_pkg::OP_READ: begin
              res_key    <= rkey;
              res_cls    <= rcls;
              res_status <= klt_pkg::ST_OK;
              state      <= S_DONE;
            end
            klt_pkg::OP_REMOVE: begin
              if (cmp.key_eq) begin
                if (idx_inc < count_ext) begin
                  idx   <= idx;
                  state <= S_SHIFT_RD;
                end else begin
                  count      <= count - 1'b1;
                  res_status <= klt_pkg::ST_OK;
                  state      <= S_DONE;
                end
              end
            end
            klt_pkg::OP_COUNT2: begin
              if (cmp.cls_pass) begin
                fcnt <= fcnt + 1'b1;
              end
            end
            default: begin
              if (cmp.cls_pass) begin
                if (8'(fcnt) == rank_r) begin
                  res_key    <= rkey;
                  res_status <= klt_pkg::ST_OK;
                  state      <= S_DONE;
                end else begin
                  fcnt <= fcnt + 1'b1;
                end
              end
            end
          endcase
        end

        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end

        S_SHIFT_WR: begin
          // Close the gap one entry at a time toward the back
          if (idx_inc2 < count_ext) begin
            idx   <= idx_inc[CW-1:0];
            state <= S_SHIFT_RD;
          end else begin
            count      <= count - 1'b1;
            res_status <= klt_pkg::ST_OK;
            state      <= S_DONE;
          end
        end

        S_SORT_RDI: begin
          state <= S_SORT_HOLD;
        end

        S_SORT_HOLD: begin
          hold_key <= rkey;
          hold_cls <= rcls;
          jdx      <= idx;
          state    <= S_SORT_RDJ;
        end

        S_SORT_RDJ: begin
          state <= S_SORT_EV;
        end

        S_SORT_EV: begin
          if (cmp.key_gt) begin
            // Larger key moves up one place; keep sinking the held entry
            jdx   <= jdx_dec;
            state <= (jdx_dec == '0) ? S_SORT_PUT : S_SORT_RDJ;
          end else if (idx_inc < count_ext) begin
            idx   <= idx_inc[CW-1:0];
            state <= S_SORT_RDI;
          end else begin
            state <= S_DONE;
          end
        end

        S_SORT_PUT: begin
          if (idx_inc < count_ext) begin
            idx   <= idx_inc[CW-1:0];
            state <= S_SORT_RDI;
          end else begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            key_out   <= res_key;
            class_out <= res_cls;
            count_out <= (op_r == klt_pkg::OP_COUNT2) ? 8'(fcnt) : 8'(count);
            status    <= res_status;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more than its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds capacity");

  // A full report is only issued against a full table
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && res_status == klt_pkg::ST_FULL)
      |-> count == CW'(MAX_ENTRIES))
    else $error("full status with room in the table");

  // The class-2 count cannot exceed the number of entries
  a_count2_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && op_r == klt_pkg::OP_COUNT2) |-> fcnt <= count)
    else $error("class-2 count above entry count");

  // Sort never compares below the front of the table
  a_sort_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT_EV) |-> jdx != '0)
    else $error("sort insertion position underflow");

  // A loaded result goes out on the next cycle
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not presented after completion");

endmodule
